/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sssp_pkg.sv */
package sssp_pkg;

	localparam int VERTEX_W = 6;
	localparam int COUNT_W  = 7;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W   = 32;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;
	localparam int DEF_WEIGHT_BITS  = 16;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_RUN = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EDGE_CHK,
		ST_EDGE_UPD,
		ST_OUT
	} state_t;

endpackage

/* rtl/single_source_shortest_path.sv */
// Channel   Direction  Handshake            Beat
// cfg       in         cfg_we               cfg_wdata (vertex count)
// request   in         in_valid / in_stall  req_type, src_vertex, dst_vertex, edge_weight,
//                                           start_vertex
// result    out        out_valid / out_stall vertex_index, distance, reachable, status, last
//
// Add edge and rejected runs: one beat in, one result beat.
// Run: per settled vertex one minimum scan over the N vertices, a check of every stored
// edge and an update per edge leaving it, then a final scan and N result beats; the
// distance memory has a single read port.
// N vertices in use.
// Reset clears the edge count, masks and handshake state; the memories are not cleared.
// Requests are taken only in idle with the result register free; result stalls hold the run.
module single_source_shortest_path
	import sssp_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [VERTEX_W-1:0] src_vertex,
	input  logic [VERTEX_W-1:0] dst_vertex,
	input  logic [WEIGHT_W-1:0] edge_weight,
	input  logic [VERTEX_W-1:0] start_vertex,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [VERTEX_W-1:0] vertex_index,
	output logic [DIST_W-1:0]   distance,
	output logic                reachable,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	`include "assert_macros.svh"

	localparam int VI_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ET_W = $clog2(MAX_EDGES + 1);
	localparam int ED_W = 2 * VI_W + WEIGHT_BITS;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]      vcount_q;
	logic [ET_W-1:0]         edge_total_q, edge_total_d;
	logic [MAX_VERTICES-1:0] settled_q, settled_d, reached_q, reached_d;
	logic [VI_W-1:0]         vidx_q, vidx_d, u_q, u_d;
	logic                    found_q, found_d;
	logic [DIST_W-1:0]       du_q, du_d;
	logic [EA_W-1:0]         edge_q, edge_d;

	logic                out_valid_q, out_valid_d;
	logic [VERTEX_W-1:0] vertex_index_q, vertex_index_d;
	logic [DIST_W-1:0]   distance_q, distance_d;
	logic                reachable_q, reachable_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                last_q, last_d;

	// active vertex count and derived limits
	logic [COUNT_W-1:0] n_act, n_m1;
	logic [VI_W-1:0]    last_idx;

	always_comb begin
		if (vcount_q == '0) begin
			n_act = COUNT_W'(1);
		end else if (vcount_q > COUNT_W'(MAX_VERTICES)) begin
			n_act = COUNT_W'(MAX_VERTICES);
		end else begin
			n_act = vcount_q;
		end
	end
	assign n_m1     = n_act - COUNT_W'(1);
	assign last_idx = n_m1[VI_W-1:0];

	// memories
	logic              edge_we, dist_we;
	logic [ED_W-1:0]   edge_wdata, edge_rdata;
	logic [VI_W-1:0]   dist_waddr, dist_raddr;
	logic [DIST_W-1:0] dist_wdata, dist_rdata;
	logic [31:0]       weight_ext;
	logic [VI_W-1:0]   e_src, e_tgt;
	logic [WEIGHT_BITS-1:0] e_cost;

	assign weight_ext = {16'b0, edge_weight};
	assign edge_wdata = {src_vertex[VI_W-1:0], dst_vertex[VI_W-1:0],
		weight_ext[WEIGHT_BITS-1:0]};
	assign {e_src, e_tgt, e_cost} = edge_rdata;

	sssp_ram #(.WIDTH(ED_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_total_q[EA_W-1:0]),
		.wdata (edge_wdata),
		.raddr (edge_d),
		.rdata (edge_rdata)
	);

	sssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// shared conditions
	logic out_free, in_take, add_bad, add_full, run_bad;
	logic cand, take_cand, scan_end, found_n, more_edges, relevant;
	logic [VI_W-1:0]   u_n;
	logic [DIST_W-1:0] du_n;
	logic [DIST_W:0]   nd_sum;
	logic [DIST_W-1:0] nd;
	logic              improve;

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = (state_q == ST_IDLE) && out_free && in_valid;
	assign in_stall = (state_q != ST_IDLE) || !out_free;

	assign add_bad  = ({1'b0, src_vertex} >= n_act) || ({1'b0, dst_vertex} >= n_act);
	assign add_full = edge_total_q == ET_W'(MAX_EDGES);
	assign run_bad  = {1'b0, start_vertex} >= n_act;

	assign cand      = reached_q[vidx_q] && !settled_q[vidx_q];
	assign take_cand = cand && (!found_q || (dist_rdata < du_q));
	assign found_n   = found_q || cand;
	assign u_n       = take_cand ? vidx_q : u_q;
	assign du_n      = take_cand ? dist_rdata : du_q;
	assign scan_end  = vidx_q == last_idx;

	assign more_edges = (ET_W'(edge_q) + ET_W'(1)) < edge_total_q;
	assign relevant   = (e_src == u_q) && (COUNT_W'(e_tgt) < n_act);

	assign nd_sum  = {1'b0, du_q} + (DIST_W + 1)'(e_cost);
	assign nd      = nd_sum[DIST_W] ? {DIST_W{1'b1}} : nd_sum[DIST_W-1:0];
	assign improve = !reached_q[e_tgt] || (nd < dist_rdata);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && (req_type == REQ_RUN) && !run_bad) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (!found_n) begin
						state_d = ST_OUT;
					end else if (edge_total_q != '0) begin
						state_d = ST_EDGE_CHK;
					end
				end
			end
			ST_EDGE_CHK: begin
				if (relevant) begin
					state_d = ST_EDGE_UPD;
				end else if (!more_edges) begin
					state_d = ST_SCAN;
				end
			end
			ST_EDGE_UPD: begin
				state_d = more_edges ? ST_EDGE_CHK : ST_SCAN;
			end
			ST_OUT: begin
				if (out_free && scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		edge_total_d   = edge_total_q;
		settled_d      = settled_q;
		reached_d      = reached_q;
		vidx_d         = vidx_q;
		u_d            = u_q;
		du_d           = du_q;
		found_d        = found_q;
		edge_d         = edge_q;
		edge_we        = 1'b0;
		dist_we        = 1'b0;
		dist_waddr     = e_tgt;
		dist_wdata     = nd;
		out_valid_d    = out_valid_q && out_stall;
		vertex_index_d = vertex_index_q;
		distance_d     = distance_q;
		reachable_d    = reachable_q;
		status_d       = status_q;
		last_d         = last_q;

		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					if (req_type == REQ_RUN && !run_bad) begin
						settled_d  = '0;
						reached_d  = '0;
						reached_d[start_vertex[VI_W-1:0]] = 1'b1;
						dist_we    = 1'b1;
						dist_waddr = start_vertex[VI_W-1:0];
						dist_wdata = '0;
						vidx_d     = '0;
						found_d    = 1'b0;
					end else begin
						out_valid_d    = 1'b1;
						vertex_index_d = '0;
						distance_d     = '0;
						reachable_d    = 1'b0;
						last_d         = 1'b1;
						if (req_type == REQ_RUN || add_bad) begin
							status_d = STATUS_RANGE;
						end else if (add_full) begin
							status_d = STATUS_FULL;
						end else begin
							status_d     = STATUS_OK;
							edge_we      = 1'b1;
							edge_total_d = edge_total_q + ET_W'(1);
						end
					end
				end
			end
			ST_SCAN: begin
				found_d = found_n;
				u_d     = u_n;
				du_d    = du_n;
				if (scan_end) begin
					vidx_d = '0;
					if (found_n) begin
						settled_d[u_n] = 1'b1;
						edge_d  = '0;
						// no edges at all: go straight to the next scan
						if (edge_total_q == '0) begin
							found_d = 1'b0;
						end
					end
				end else begin
					vidx_d = vidx_q + VI_W'(1);
				end
			end
			ST_EDGE_CHK: begin
				if (!relevant) begin
					if (more_edges) begin
						edge_d = edge_q + EA_W'(1);
					end else begin
						vidx_d  = '0;
						found_d = 1'b0;
					end
				end
			end
			ST_EDGE_UPD: begin
				if (improve) begin
					dist_we          = 1'b1;
					reached_d[e_tgt] = 1'b1;
				end
				if (more_edges) begin
					edge_d = edge_q + EA_W'(1);
				end else begin
					vidx_d  = '0;
					found_d = 1'b0;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_valid_d    = 1'b1;
					vertex_index_d = VERTEX_W'(vidx_q);
					distance_d     = reached_q[vidx_q] ? dist_rdata : '0;
					reachable_d    = reached_q[vidx_q];
					status_d       = STATUS_OK;
					last_d         = scan_end;
					vidx_d         = scan_end ? '0 : vidx_q + VI_W'(1);
				end
			end
			default: ;
		endcase
	end

	// distance read address follows the next index, or the edge target before an update, so the registered data lines up
	assign dist_raddr = (state_d == ST_EDGE_UPD) ? e_tgt : vidx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= COUNT_W'(1);
			edge_total_q <= '0;
			settled_q    <= '0;
			reached_q    <= '0;
			vidx_q       <= '0;
			found_q      <= 1'b0;
			edge_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			edge_total_q <= edge_total_d;
			settled_q    <= settled_d;
			reached_q    <= reached_d;
			vidx_q       <= vidx_d;
			found_q      <= found_d;
			edge_q       <= edge_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		u_q            <= u_d;
		du_q           <= du_d;
		vertex_index_q <= vertex_index_d;
		distance_q     <= distance_d;
		reachable_q    <= reachable_d;
		status_q       <= status_d;
		last_q         <= last_d;
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign distance     = distance_q;
	assign reachable    = reachable_q;
	assign status       = status_q;
	assign last         = last_q;

	`ASSERT_CLK(a_ready_only_idle, !in_stall |-> state_q == ST_IDLE, "ready outside idle")
	`ASSERT_CLK(a_settled_reached, (settled_q & ~reached_q) == '0, "settled vertex not reached")
	`ASSERT_CLK(a_edge_total_max, edge_total_q <= ET_W'(MAX_EDGES), "edge count overflow")
	`ASSERT_CLK(a_upd_after_chk, state_q == ST_EDGE_UPD |-> $past(state_q) == ST_EDGE_CHK,
		"update without edge check")
	`ASSERT_CLK(a_err_is_last, out_valid_q && status_q != STATUS_OK |-> last_q,
		"error result not last")

endmodule

/* rtl/sssp_ram.sv */
module sssp_ram
	import sssp_pkg::*;
#(
	parameter int WIDTH = DIST_W,
	parameter int DEPTH = DEF_MAX_VERTICES,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write-first: a read of the address being written returns the new word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule
